// ===== hw/rtl/arcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcr_pkg
// Shared types and codes for the address range cache router.
// ----------------------------------------------------------------------------
package arcr_pkg;

  localparam int MAX_RULES_DEF = 16;

  localparam int ADDR_W   = 64;
  localparam int SIZE_W   = 32;
  localparam int IDXIN_W  = 32;
  localparam int BOUND_W  = 32;
  localparam int LAT_W    = 16;
  localparam int RCNT_W   = 5;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Item operations
  localparam logic OP_ROUTE = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Bound select
  localparam logic SEL_START = 1'b0;
  localparam logic SEL_END   = 1'b1;

  // Write status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_ALL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LATENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT    = 2'd2;

  // Word travelling down the cell chain
  typedef struct packed {
    logic                    op;
    logic                    sel;
    logic                    kill;    // request can never match
    logic [BOUND_W-1:0]      val;
    logic [ADDR_W-1:0]       addr;
    logic [ADDR_W-1:0]       lim;     // addr + size, valid when kill is low
    logic                    hit;
    logic [STAT_W-1:0]       status;
  } arcr_tok_t;

endpackage
`default_nettype wire

// ===== hw/rtl/arcr_ingress.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcr_ingress
// Decodes an input word into a chain word: range limit, no-match and index check.
// ----------------------------------------------------------------------------
module arcr_ingress #(
  parameter int MAX_RULES = arcr_pkg::MAX_RULES_DEF,
  parameter int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
  parameter int CNT_W     = $clog2(MAX_RULES + 1)
) (
  input  wire logic                         in_operation,
  input  wire logic [arcr_pkg::ADDR_W-1:0]  in_addr,
  input  wire logic [arcr_pkg::SIZE_W-1:0]  in_size,
  input  wire logic [arcr_pkg::IDXIN_W-1:0] in_rule_index,
  input  wire logic                         in_bound_select,
  input  wire logic [arcr_pkg::BOUND_W-1:0] in_bound_value,
  input  wire logic                         bypass_all,
  input  wire logic [arcr_pkg::RCNT_W-1:0]  rule_count,
  output arcr_pkg::arcr_tok_t               tok,
  output logic [IDX_W-1:0]                  idx,
  output logic [CNT_W-1:0]                  act_cnt
);
  import arcr_pkg::*;

  logic [ADDR_W:0] sum;
  logic [31:0]     rc_ext;
  logic [31:0]     act_ext;

  always_comb begin
    rc_ext  = 32'(rule_count);
    act_ext = (rc_ext > 32'(MAX_RULES)) ? 32'(MAX_RULES) : rc_ext;
    act_cnt = CNT_W'(act_ext);

    sum = {1'b0, in_addr} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, in_size};

    tok.op     = in_operation;
    tok.sel    = in_bound_select;
    tok.val    = in_bound_value;
    tok.addr   = in_addr;
    tok.lim    = sum[ADDR_W-1:0];
    tok.hit    = 1'b0;
    tok.kill   = bypass_all || (in_size == '0) || sum[ADDR_W];
    tok.status = ST_OK;
    if (in_operation == OP_WRITE && in_rule_index >= act_ext) begin
      tok.status = ST_BADIDX;
    end
    idx = IDX_W'(in_rule_index);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/arcr_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcr_cell
// One rule slot: holds its interval, tests it or rewrites it, passes the word on.
// ----------------------------------------------------------------------------
module arcr_cell #(
  parameter int CELL_ID = 0,
  parameter int IDX_W   = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                active,
  input  wire logic                vld_i,
  input  wire arcr_pkg::arcr_tok_t tok_i,
  input  wire logic [IDX_W-1:0]    idx_i,
  output logic                     vld_o,
  output arcr_pkg::arcr_tok_t      tok_o,
  output logic [IDX_W-1:0]         idx_o
);
  import arcr_pkg::*;

  logic [BOUND_W-1:0] start_r, start_nxt;
  logic [BOUND_W-1:0] end_r, end_nxt;
  logic               vld_r;
  arcr_tok_t          tok_r, tok_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [BOUND_W-1:0] new_s, new_e;
  logic               hit_here;

  always_comb begin
    hit_here = active && (start_r < end_r)
               && ({{(ADDR_W - BOUND_W){1'b0}}, start_r} < tok_i.lim)
               && ({{(ADDR_W - BOUND_W){1'b0}}, end_r} > tok_i.addr)
               && !tok_i.kill && (tok_i.op == OP_ROUTE);

    new_s = (tok_i.sel == SEL_START) ? tok_i.val : start_r;
    new_e = (tok_i.sel == SEL_END)   ? tok_i.val : end_r;

    tok_nxt     = tok_i;
    tok_nxt.hit = tok_i.hit | hit_here;
    start_nxt   = start_r;
    end_nxt     = end_r;
    if (vld_i && tok_i.op == OP_WRITE && tok_i.status == ST_OK
        && idx_i == IDX_W'(CELL_ID)) begin
      if (new_s >= new_e) begin
        tok_nxt.status = ST_EMPTY;
      end else begin
        start_nxt = new_s;
        end_nxt   = new_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      start_r <= '0;
      end_r   <= '0;
    end else if (adv) begin
      vld_r   <= vld_i;
      start_r <= start_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
      idx_r <= idx_i;
    end
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule
`default_nettype wire

// ===== hw/rtl/address_range_cache_router_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_range_cache_router_unit
// Routes requests to cache or bypass by rule interval overlap; rewrites rule bounds.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  in_      | input     | in_valid/in_ready  | operation, addr, size, rule_index,
//           |           |                    | bound_select, bound_value
//  out_     | output    | out_valid/out_ready| to_cache, added_latency, write_status
//  cfg_     | input     | cfg_we             | cfg_index, cfg_wdata
//
//  One word at a time walks a chain of MAX_RULES cells, one cell per cycle while
//  the output does not stall, from the head register through the cells into the
//  output register. The next word is accepted once the previous one has left the
//  chain, even while its result still waits. Reset (synchronous, active low)
//  clears all rules, the configuration registers, the busy flag and all valids.
//  A stalled output holds the chain once the word in flight reaches the tail.
//
module address_range_cache_router_unit #(
  parameter int MAX_RULES = arcr_pkg::MAX_RULES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_operation,
  input  wire logic [arcr_pkg::ADDR_W-1:0]    in_addr,
  input  wire logic [arcr_pkg::SIZE_W-1:0]    in_size,
  input  wire logic [arcr_pkg::IDXIN_W-1:0]   in_rule_index,
  input  wire logic                           in_bound_select,
  input  wire logic [arcr_pkg::BOUND_W-1:0]   in_bound_value,

  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_to_cache,
  output logic [arcr_pkg::LAT_W-1:0]          out_added_latency,
  output logic [arcr_pkg::STAT_W-1:0]         out_write_status,

  input  wire logic                           cfg_we,
  input  wire logic [arcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [arcr_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import arcr_pkg::*;

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  // Configuration registers
  logic              bypass_all_r;
  logic [LAT_W-1:0]  cache_latency_r;
  logic [RCNT_W-1:0] rule_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_all_r    <= 1'b0;
      cache_latency_r <= '0;
      rule_count_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYPASS_ALL:    bypass_all_r    <= cfg_wdata[0];
        CFG_CACHE_LATENCY: cache_latency_r <= cfg_wdata[LAT_W-1:0];
        CFG_RULE_COUNT:    rule_count_r    <= cfg_wdata[RCNT_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Decode the incoming word
  arcr_tok_t        in_tok;
  logic [IDX_W-1:0] in_idx;
  logic [CNT_W-1:0] act_cnt;

  arcr_ingress #(
    .MAX_RULES (MAX_RULES),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ingress (
    .in_operation    (in_operation),
    .in_addr         (in_addr),
    .in_size         (in_size),
    .in_rule_index   (in_rule_index),
    .in_bound_select (in_bound_select),
    .in_bound_value  (in_bound_value),
    .bypass_all      (bypass_all_r),
    .rule_count      (rule_count_r),
    .tok             (in_tok),
    .idx             (in_idx),
    .act_cnt         (act_cnt)
  );

  // Head register and busy flag: one word in the chain at a time
  logic             busy_r, busy_nxt;
  logic             head_vld_r, head_vld_nxt;
  arcr_tok_t        head_tok_r;
  logic [IDX_W-1:0] head_idx_r;
  logic             in_acc;
  logic             adv;
  logic             tail_take;

  logic             vld_w [0:MAX_RULES];
  arcr_tok_t        tok_w [0:MAX_RULES];
  logic [IDX_W-1:0] idx_w [0:MAX_RULES];

  logic             out_valid_r, out_valid_nxt;
  logic             out_to_cache_r;
  logic [LAT_W-1:0] out_added_latency_r;
  logic [STAT_W-1:0] out_write_status_r;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;

  // Hold the whole chain when the tail word cannot move into the output register
  assign adv       = !(vld_w[MAX_RULES] && out_valid_r && !out_ready);
  assign tail_take = vld_w[MAX_RULES] && adv;

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (tail_take) begin
      busy_nxt = 1'b0;
    end

    head_vld_nxt = head_vld_r;
    if (in_acc) begin
      head_vld_nxt = 1'b1;
    end else if (adv) begin
      head_vld_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (tail_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      head_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      head_vld_r  <= head_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      head_tok_r <= in_tok;
      head_idx_r <= in_idx;
    end
  end

  assign vld_w[0] = head_vld_r;
  assign tok_w[0] = head_tok_r;
  assign idx_w[0] = head_idx_r;

  // Chain of rule cells
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    logic active;
    assign active = (CNT_W'(i) < act_cnt);

    arcr_cell #(
      .CELL_ID (i),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .active (active),
      .vld_i  (vld_w[i]),
      .tok_i  (tok_w[i]),
      .idx_i  (idx_w[i]),
      .vld_o  (vld_w[i+1]),
      .tok_o  (tok_w[i+1]),
      .idx_o  (idx_w[i+1])
    );
  end

  // Output register: format the result from the tail word
  always_ff @(posedge clk) begin
    if (tail_take) begin
      out_to_cache_r      <= (tok_w[MAX_RULES].op == OP_ROUTE) && tok_w[MAX_RULES].hit;
      out_added_latency_r <= ((tok_w[MAX_RULES].op == OP_ROUTE) && tok_w[MAX_RULES].hit)
                             ? cache_latency_r : '0;
      out_write_status_r  <= (tok_w[MAX_RULES].op == OP_WRITE)
                             ? tok_w[MAX_RULES].status : ST_OK;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_to_cache      = out_to_cache_r;
  assign out_added_latency = out_added_latency_r;
  assign out_write_status  = out_write_status_r;

endmodule
`default_nettype wire

// ===== hw/rtl/arcr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arcr_checker
// Port-level checks on the router, bound to the top level.
// ----------------------------------------------------------------------------
module arcr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           out_to_cache,
  input wire logic [arcr_pkg::LAT_W-1:0]     out_added_latency,
  input wire logic [arcr_pkg::STAT_W-1:0]    out_write_status
);
  import arcr_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_to_cache)
      && $stable(out_added_latency) && $stable(out_write_status))
    else $error("result changed while stalled");

  // One word in flight: an accepted word closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A refused write never routes to the cache
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_status != ST_OK |-> !out_to_cache && out_added_latency == '0)
    else $error("write result carries routing data");

endmodule

bind address_range_cache_router_unit arcr_checker u_arcr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_to_cache      (out_to_cache),
  .out_added_latency (out_added_latency),
  .out_write_status  (out_write_status)
);
`default_nettype wire

// ===== dv/tb_address_range_cache_router_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_range_cache_router_unit
// Self-checking bench for the address range cache router. Directed words hit
// the corner cases first. Random rule setups, requests and noise words follow
// under several register settings and idle patterns, with one long output
// stall. Each result is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_address_range_cache_router_unit;
  import arcr_pkg::*;

  localparam int MAX_RULES     = MAX_RULES_DEF;
  localparam int CHAIN_LAT     = MAX_RULES + 1;
  localparam int STALL_CYCLES  = 400;            // long output hold-off
  localparam int WATCHDOG_LIM  = 4000;           // cycles with no handshake at all

  // One input word as the sender sees it.
  typedef struct packed {
    logic               op;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
    logic [IDXIN_W-1:0] idx;
    logic               sel;
    logic [BOUND_W-1:0] val;
  } router_word_t;

  // One result word as the receiver sees it.
  typedef struct packed {
    logic              to_cache;
    logic [LAT_W-1:0]  latency;
    logic [STAT_W-1:0] status;
  } route_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic               in_operation    = OP_ROUTE;
  logic [ADDR_W-1:0]  in_addr         = '0;
  logic [SIZE_W-1:0]  in_size         = '0;
  logic [IDXIN_W-1:0] in_rule_index   = '0;
  logic               in_bound_select = SEL_START;
  logic [BOUND_W-1:0] in_bound_value  = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_to_cache;
  logic [LAT_W-1:0]   out_added_latency;
  logic [STAT_W-1:0]  out_write_status;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  address_range_cache_router_unit #(
    .MAX_RULES(MAX_RULES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_addr          (in_addr),
    .in_size          (in_size),
    .in_rule_index    (in_rule_index),
    .in_bound_select  (in_bound_select),
    .in_bound_value   (in_bound_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_to_cache     (out_to_cache),
    .out_added_latency(out_added_latency),
    .out_write_status (out_write_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench state: pending words, results due, predictor copy of rules and regs
  // --------------------------------------------------------------------------
  router_word_t  pending_words[$];
  route_result_t routing_due_q[$];
  router_word_t  word_on_bus;
  route_result_t due;

  logic [ADDR_W-1:0] rule_lo [MAX_RULES] = '{default: '0};
  logic [ADDR_W-1:0] rule_hi [MAX_RULES] = '{default: '0};
  logic              bypass_all_m    = 1'b0;
  logic [LAT_W-1:0]  cache_latency_m = '0;
  logic [RCNT_W-1:0] rules_in_use_m  = '0;

  int unsigned send_idle_pct  = 15;
  int unsigned recv_idle_pct  = 49;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_left      = 0;
  logic        hold_req       = 1'b0;
  logic        hold_done      = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor: route or rule-write outcome for one accepted word
  // --------------------------------------------------------------------------
  function automatic route_result_t predict_route(input router_word_t w);
    route_result_t     r;
    logic [ADDR_W:0]   reach;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    int unsigned       live;
    r    = '0;
    // Clamp the rule count to the table depth.
    live = (rules_in_use_m > MAX_RULES) ? MAX_RULES : rules_in_use_m;
    if (w.op == OP_ROUTE) begin
      // Keep the carry so a range running past the top of memory is seen.
      reach = {1'b0, w.addr} + {{(ADDR_W - SIZE_W + 1){1'b0}}, w.size};
      if (!bypass_all_m && w.size != '0 && !reach[ADDR_W]) begin
        for (int i = 0; i < live; i++) begin
          if (rule_lo[i] < rule_hi[i] && rule_lo[i] < reach[ADDR_W-1:0] &&
              rule_hi[i] > w.addr)
            r.to_cache = 1'b1;
        end
      end
      if (r.to_cache)
        r.latency = cache_latency_m;
    end else if (w.idx >= live) begin
      // Index check comes before the interval check.
      r.status = ST_BADIDX;
    end else begin
      lo = rule_lo[w.idx];
      hi = rule_hi[w.idx];
      if (w.sel == SEL_START)
        lo = {{(ADDR_W - BOUND_W){1'b0}}, w.val};
      else
        hi = {{(ADDR_W - BOUND_W){1'b0}}, w.val};
      if (lo >= hi) begin
        r.status = ST_EMPTY;
      end else begin
        rule_lo[w.idx] = lo;
        rule_hi[w.idx] = hi;
        r.status       = ST_OK;
      end
    end
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present words from the pending queue, predict on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict the word taken at this edge before the next one goes out.
      if (in_valid && in_ready)
        routing_due_q.insert(routing_due_q.size(), predict_route(word_on_bus));
      // Advance only when the bus is free or its word was just taken.
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          word_on_bus      = pending_words.pop_front();
          in_operation    <= word_on_bus.op;
          in_addr         <= word_on_bus.addr;
          in_size         <= word_on_bus.size;
          in_rule_index   <= word_on_bus.idx;
          in_bound_select <= word_on_bus.sel;
          in_bound_value  <= word_on_bus.val;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long output stall, counted in its own process
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= STALL_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result word against the oldest one due
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (routing_due_q.size() == 0) begin
          flag_mismatch("result with nothing due", 64'({out_to_cache, out_added_latency,
                        out_write_status}), '0);
        end else begin
          due = routing_due_q.pop_front();
          if (out_to_cache !== due.to_cache)
            flag_mismatch("to_cache", 64'(out_to_cache), 64'(due.to_cache));
          if (out_added_latency !== due.latency)
            flag_mismatch("added_latency", 64'(out_added_latency), 64'(due.latency));
          if (out_write_status !== due.status)
            flag_mismatch("write_status", 64'(out_write_status), 64'(due.status));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no word moves on either side for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIM) begin
        $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; unused fields of each word get random values
  // --------------------------------------------------------------------------
  task automatic push_route(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size);
    router_word_t w;
    w = '{op: OP_ROUTE, addr: addr, size: size, idx: $urandom,
          sel: 1'($urandom_range(0, 1)), val: $urandom};
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_write(input logic [IDXIN_W-1:0] idx, input logic sel,
                            input logic [BOUND_W-1:0] val);
    router_word_t w;
    w = '{op: OP_WRITE, addr: {$urandom, $urandom}, size: $urandom, idx: idx,
          sel: sel, val: val};
    pending_words.insert(pending_words.size(), w);
  endtask

  // Write one register at the next edge and mirror it into the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BYPASS_ALL:    bypass_all_m    = data[0];
      CFG_CACHE_LATENCY: cache_latency_m = data;
      CFG_RULE_COUNT:    rules_in_use_m  = data[RCNT_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the write enable, then line up on a falling edge for queue pushes.
  task automatic end_writes;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every word is sent and every result has come back.
  task automatic drain;
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || routing_due_q.size() != 0);
  endtask

  // Fill the queue with a random mix: mostly rule setups and requests aimed at
  // the rules, the rest noise words, wrapping ranges and bad indexes.
  task automatic queue_random_words(input int count);
    int          made;
    int          pick;
    int          live;
    logic [31:0] base;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] slot;
    base = $urandom_range('h1000, 'hFFFF0000);
    live = (rules_in_use_m > MAX_RULES) ? MAX_RULES : rules_in_use_m;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // Clear start, set end, then set start below it: a clean rule setup.
        slot = (live == 0 || $urandom_range(0, 7) == 0) ?
               $urandom_range(0, MAX_RULES - 1) : $urandom_range(0, live - 1);
        hi = base + $urandom_range(1, 'h4000);
        lo = hi - $urandom_range(1, 'h1000);
        push_write(slot, SEL_START, '0);
        push_write(slot, SEL_END, hi);
        push_write(slot, SEL_START, lo);
        made += 3;
      end else if (pick < 80) begin
        push_route({32'b0, base} - 64'h800 + $urandom_range(0, 'h5000),
                   ($urandom_range(0, 15) == 0) ? '0 : $urandom_range(1, 'h400));
        made++;
      end else if (pick < 90) begin
        push_write($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * MAX_RULES),
                   1'($urandom_range(0, 1)), $urandom);
        made++;
      end else begin
        if ($urandom_range(0, 1))
          push_route({$urandom, $urandom}, $urandom);
        else
          push_route('1 - 64'($urandom_range(0, 'hFFFF)), $urandom_range(0, 'h20000));
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers at reset: no rules in use, so a write hits a bad index.
    push_route(64'h0, 32'h1);
    push_write(32'h0, SEL_END, 32'h100);
    drain();

    write_reg(CFG_RULE_COUNT, 16'(MAX_RULES));
    write_reg(CFG_CACHE_LATENCY, 16'hFFFF);
    write_reg(CFG_BYPASS_ALL, 16'h0);
    end_writes();
    push_write(32'h0, SEL_START, 32'h10);         // end still zero: empty interval
    push_write(32'h0, SEL_END, 32'h100);
    push_write(32'h0, SEL_START, 32'h10);         // rule 0 is [0x10, 0x100)
    push_write(32'h0, SEL_START, 32'h100);        // start equal to end: refused
    push_write(32'(MAX_RULES - 1), SEL_END, 32'hFFFF_FFFF);
    push_write(32'(MAX_RULES - 1), SEL_START, 32'hFFFF_FFFE);
    push_write(32'(MAX_RULES), SEL_END, 32'h1);   // one past the last rule
    push_write(32'hFFFF_FFFF, SEL_END, 32'h1);
    push_route(64'hF, 32'h1);                     // ends right at the rule start
    push_route(64'hF, 32'h2);                     // overlaps by one byte
    push_route(64'hFF, 32'h1);                    // last byte of the rule
    push_route(64'h100, 32'h10);                  // starts at the rule end
    push_route(64'h20, 32'h0);                    // zero size never matches
    push_route(64'hFFFF_FFFF_FFFF_FFF0, 32'h20);  // wraps past the top
    push_route(64'hFFFF_FFFF_FFFF_FFFF, 32'h1);   // wraps to exactly zero
    push_route(64'hFFFF_FFFF_FFFF_FFFE, 32'h1);   // top byte, no wrap
    push_route(64'h0, 32'hFFFF_FFFF);             // widest size
    push_route(64'hFFFF_FFFE, 32'h1);             // highest rule
    drain();

    // Global bypass wins over a hit.
    write_reg(CFG_BYPASS_ALL, 16'hFFFF);
    end_writes();
    push_route(64'h20, 32'h4);
    drain();

    // Rule count above the table depth saturates.
    write_reg(CFG_BYPASS_ALL, 16'h0);
    write_reg(CFG_RULE_COUNT, 16'h001F);
    end_writes();
    push_write(32'(MAX_RULES - 1), SEL_END, 32'hFFFF_FFFF);
    push_route(64'hFFFF_FFFE, 32'h1);
    drain();

    // A single rule in use hides the others.
    write_reg(CFG_RULE_COUNT, 16'h1);
    end_writes();
    push_route(64'hFFFF_FFFE, 32'h1);
    push_write(32'h1, SEL_END, 32'h40);
    drain();

    // Random part, sender idles lightly and receiver heavily.
    write_reg(CFG_RULE_COUNT, 16'({$urandom, 5'($urandom_range(1, MAX_RULES))}));
    write_reg(CFG_CACHE_LATENCY, 16'($urandom));
    end_writes();
    send_idle_pct = 15;
    recv_idle_pct = 49;
    queue_random_words(260);
    drain();

    // The other way round, with a saturated count and zero latency.
    write_reg(CFG_RULE_COUNT, 16'({$urandom, 5'h1F}));
    write_reg(CFG_CACHE_LATENCY, 16'h0);
    end_writes();
    send_idle_pct = 49;
    recv_idle_pct = 15;
    queue_random_words(260);
    drain();

    // No idling, with one long output stall so the block backs up.
    write_reg(CFG_RULE_COUNT, 16'(MAX_RULES));
    write_reg(CFG_CACHE_LATENCY, 16'hFFFF);
    end_writes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_words(260);
    hold_req = 1'b1;
    drain();

    // Bypass on with a random count, then done.
    write_reg(CFG_BYPASS_ALL, 16'h1);
    write_reg(CFG_RULE_COUNT, 16'($urandom_range(0, MAX_RULES)));
    end_writes();
    queue_random_words(100);
    drain();

    // Let any stray result show up before the verdict.
    repeat (4 * CHAIN_LAT) @(negedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/arcr_pkg.sv
hw/rtl/arcr_ingress.sv
hw/rtl/arcr_cell.sv
hw/rtl/address_range_cache_router_unit.sv
hw/rtl/arcr_checker.sv
dv/tb_address_range_cache_router_unit.sv
